>>> design/json_structure_validator_macros.svh
// Assertion macros for the JSON structure validator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef JSON_STRUCTURE_VALIDATOR_MACROS_SVH
`define JSON_STRUCTURE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSV_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("json_structure_validator assertion failed");

// Next-cycle implication, disabled during reset.
`define JSV_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("json_structure_validator assertion failed");

// Next-cycle implication that also holds across reset.
`define JSV_ASSERT_RST(name, pre, post) \
  name: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("json_structure_validator assertion failed");

`endif

>>> design/jsv_pkg.sv
// Shared types and constants of the JSON structure validator.
// No dependencies; used by the classifier, queue, parser and top level.
package jsv_pkg;

  typedef enum logic [3:0] {
    PH_VALUE        = 4'd0,
    PH_VAL_OR_CLOSE = 4'd1,
    PH_KEY_OR_CLOSE = 4'd2,
    PH_KEY          = 4'd3,
    PH_COLON        = 4'd4,
    PH_PRIM         = 4'd5,
    PH_AFTER        = 4'd6,
    PH_STR_VAL      = 4'd7,
    PH_ESC_VAL      = 4'd8,
    PH_HEX_VAL      = 4'd9,
    PH_STR_KEY      = 4'd10,
    PH_ESC_KEY      = 4'd11,
    PH_HEX_KEY      = 4'd12
  } phase_t;

  // Classified byte as it travels from the front end to the parser.
  typedef struct packed {
    logic last;
    logic ws;
    logic quote;
    logic lbrace;
    logic lbrack;
    logic rbrace;
    logic rbrack;
    logic comma;
    logic colon;
    logic bslash;
    logic ctrl;
    logic hex;
    logic esc_simple;
    logic esc_u;
  } item_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

endpackage

>>> design/jsv_classifier.sv
// Front end: accepts input transactions and classifies each byte.
// Depends on jsv_pkg; feeds jsv_fifo.
module jsv_classifier (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      byte_req,
  input  logic            last,
  output logic            item_valid,
  output jsv_pkg::item_t  item,
  input  logic            item_ready
);

  jsv_pkg::item_t cls;

  always_comb begin
    cls            = '0;
    cls.last       = last;
    cls.ws         = (byte_req == jsv_pkg::CH_SPACE) ||
                     (byte_req >= jsv_pkg::CH_TAB && byte_req <= jsv_pkg::CH_CR);
    cls.quote      = (byte_req == jsv_pkg::CH_QUOTE);
    cls.lbrace     = (byte_req == jsv_pkg::CH_LBRACE);
    cls.lbrack     = (byte_req == jsv_pkg::CH_LBRACK);
    cls.rbrace     = (byte_req == jsv_pkg::CH_RBRACE);
    cls.rbrack     = (byte_req == jsv_pkg::CH_RBRACK);
    cls.comma      = (byte_req == jsv_pkg::CH_COMMA);
    cls.colon      = (byte_req == jsv_pkg::CH_COLON);
    cls.bslash     = (byte_req == jsv_pkg::CH_BSLASH);
    cls.ctrl       = (byte_req < jsv_pkg::CTRL_LIMIT);
    cls.hex        = (byte_req >= jsv_pkg::CH_0  && byte_req <= jsv_pkg::CH_9)  ||
                     (byte_req >= jsv_pkg::CH_LA && byte_req <= jsv_pkg::CH_LF) ||
                     (byte_req >= jsv_pkg::CH_UA && byte_req <= jsv_pkg::CH_UF);
    cls.esc_simple = (byte_req == jsv_pkg::CH_QUOTE) || (byte_req == jsv_pkg::CH_BSLASH) ||
                     (byte_req == jsv_pkg::CH_SLASH) || (byte_req == jsv_pkg::CH_B) ||
                     (byte_req == jsv_pkg::CH_F) || (byte_req == jsv_pkg::CH_N) ||
                     (byte_req == jsv_pkg::CH_R) || (byte_req == jsv_pkg::CH_T);
    cls.esc_u      = (byte_req == jsv_pkg::CH_U);
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= cls;
    end
  end

endmodule

>>> design/jsv_fifo.sv
// Two-entry queue of classified bytes between front end and parser.
// Depends on jsv_pkg.
module jsv_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsv_pkg::item_t  push_item,
  output logic            full,
  output logic            head_valid,
  output jsv_pkg::item_t  head,
  input  logic            pop
);

  jsv_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/jsv_parser.sv
// Back end: parser state machine, nesting stack and result register.
// Depends on jsv_pkg; consumes classified bytes from jsv_fifo.
module jsv_parser #(
  parameter int MAX_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      base_depth,
  input  logic            head_valid,
  input  jsv_pkg::item_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            accepted
);

  localparam int LW  = $clog2(MAX_DEPTH + 1);
  localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SW  = ((LW > 4) ? LW : 4) + 1;

  jsv_pkg::phase_t phase, phase_next;
  logic [LW-1:0]   level, level_next, lvl_m1;
  logic [2:0]      hex_left, hex_next;
  logic            rejected, rej_next;
  logic [MAX_DEPTH-1:0] stack;

  logic push, push_kind, top_kind, deep, vstart, after, key, ok;
  jsv_pkg::item_t c;

  assign c      = head;
  assign lvl_m1 = level - LW'(1);
  assign top_kind = (level != '0) ? stack[lvl_m1[SIW-1:0]] : 1'b0;
  assign deep   = (SW'(base_depth) + SW'(level)) >= SW'(MAX_DEPTH);
  assign pop    = head_valid && (!head.last || !out_valid || out_ready);

  always_comb begin
    phase_next = phase;
    level_next = level;
    hex_next   = hex_left;
    rej_next   = rejected;
    push       = 1'b0;
    push_kind  = 1'b0;
    vstart     = 1'b0;
    after      = 1'b0;
    key        = (phase == jsv_pkg::PH_STR_KEY) || (phase == jsv_pkg::PH_ESC_KEY) ||
                 (phase == jsv_pkg::PH_HEX_KEY);
    if (!rejected) begin
      unique case (phase)
        jsv_pkg::PH_VALUE: begin
          if (!c.ws) vstart = 1'b1;
        end
        jsv_pkg::PH_VAL_OR_CLOSE: begin
          if (!c.ws) begin
            if (c.rbrack) begin
              level_next = lvl_m1;
              phase_next = jsv_pkg::PH_AFTER;
            end else begin
              vstart = 1'b1;
            end
          end
        end
        jsv_pkg::PH_KEY_OR_CLOSE: begin
          if (!c.ws) begin
            if (c.rbrace) begin
              level_next = lvl_m1;
              phase_next = jsv_pkg::PH_AFTER;
            end else if (c.quote) begin
              phase_next = jsv_pkg::PH_STR_KEY;
            end else begin
              rej_next = 1'b1;
            end
          end
        end
        jsv_pkg::PH_KEY: begin
          if (!c.ws) begin
            if (c.quote) phase_next = jsv_pkg::PH_STR_KEY;
            else rej_next = 1'b1;
          end
        end
        jsv_pkg::PH_COLON: begin
          if (!c.ws) begin
            if (c.colon) phase_next = jsv_pkg::PH_VALUE;
            else rej_next = 1'b1;
          end
        end
        jsv_pkg::PH_PRIM: begin
          if (c.comma || c.rbrace || c.rbrack || c.ws) after = 1'b1;
        end
        jsv_pkg::PH_AFTER: begin
          after = 1'b1;
        end
        jsv_pkg::PH_STR_VAL, jsv_pkg::PH_STR_KEY: begin
          if (c.quote) begin
            phase_next = key ? jsv_pkg::PH_COLON : jsv_pkg::PH_AFTER;
          end else if (c.ctrl) begin
            rej_next = 1'b1;
          end else if (c.bslash) begin
            phase_next = key ? jsv_pkg::PH_ESC_KEY : jsv_pkg::PH_ESC_VAL;
          end
        end
        jsv_pkg::PH_ESC_VAL, jsv_pkg::PH_ESC_KEY: begin
          if (c.esc_simple) begin
            phase_next = key ? jsv_pkg::PH_STR_KEY : jsv_pkg::PH_STR_VAL;
          end else if (c.esc_u) begin
            hex_next   = jsv_pkg::HEX_DIGITS;
            phase_next = key ? jsv_pkg::PH_HEX_KEY : jsv_pkg::PH_HEX_VAL;
          end else begin
            rej_next = 1'b1;
          end
        end
        jsv_pkg::PH_HEX_VAL, jsv_pkg::PH_HEX_KEY: begin
          if (!c.hex) begin
            rej_next = 1'b1;
          end else begin
            hex_next = hex_left - 3'd1;
            if (hex_left == 3'd1) begin
              phase_next = key ? jsv_pkg::PH_STR_KEY : jsv_pkg::PH_STR_VAL;
            end
          end
        end
        default: begin
          rej_next = 1'b1;
        end
      endcase

      if (vstart) begin
        if (c.quote) begin
          phase_next = jsv_pkg::PH_STR_VAL;
        end else if (c.lbrace || c.lbrack) begin
          if (deep) begin
            rej_next = 1'b1;
          end else begin
            push       = 1'b1;
            push_kind  = c.lbrace;
            level_next = level + LW'(1);
            phase_next = c.lbrace ? jsv_pkg::PH_KEY_OR_CLOSE : jsv_pkg::PH_VAL_OR_CLOSE;
          end
        end else if (c.comma || c.rbrace || c.rbrack) begin
          rej_next = 1'b1;
        end else begin
          phase_next = jsv_pkg::PH_PRIM;
        end
      end

      if (after) begin
        phase_next = jsv_pkg::PH_AFTER;
        if (!c.ws) begin
          if (level == '0) begin
            rej_next = 1'b1;
          end else if (c.comma) begin
            phase_next = top_kind ? jsv_pkg::PH_KEY : jsv_pkg::PH_VALUE;
          end else if (top_kind ? c.rbrace : c.rbrack) begin
            level_next = lvl_m1;
          end else begin
            rej_next = 1'b1;
          end
        end
      end
    end

    ok = !rej_next && (level_next == '0) &&
         ((phase_next == jsv_pkg::PH_AFTER) || (phase_next == jsv_pkg::PH_PRIM));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jsv_pkg::PH_VALUE;
      level     <= '0;
      hex_left  <= 3'd0;
      rejected  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (pop && c.last);
      if (pop) begin
        if (c.last) begin
          phase     <= jsv_pkg::PH_VALUE;
          level     <= '0;
          hex_left  <= 3'd0;
          rejected  <= 1'b0;
        end else begin
          phase    <= phase_next;
          level    <= level_next;
          hex_left <= hex_next;
          rejected <= rej_next;
        end
      end
    end
  end

  // Only entries below the current level are ever read, so no reset.
  always_ff @(posedge clk) begin
    if (pop && c.last) begin
      accepted <= ok;
    end
    if (pop && push) begin
      stack[level[SIW-1:0]] <= push_kind;
    end
  end

endmodule

>>> design/json_structure_validator.sv
// JSON structure validator top level: config register, front end, queue, parser.
// Depends on jsv_pkg, jsv_classifier, jsv_fifo and jsv_parser.
//
// Checks that a byte stream, one byte per input transaction with a last mark,
// holds exactly one lax JSON value, and returns one result transaction
// (accepted = 1 or 0) for the byte marked last. Throughput is one byte per
// cycle unless a stalled result holds input off, set by the parser's state
// update; the result passes from the front register through the queue and
// the parser into the output register. A stalled result backs up through a
// two-entry queue before input is held off. base_depth (written through cfg_*)
// counts toward MAX_DEPTH when a container opens; write it only while idle.
module json_structure_validator #(
  parameter int MAX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_req,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic           base_depth_en;
  logic [3:0]     base_depth;
  logic           f_valid;
  jsv_pkg::item_t f_item;
  logic           q_full;
  logic           q_valid;
  jsv_pkg::item_t q_head;
  logic           q_pop;

  assign cfg_ready     = 1'b1;
  assign base_depth_en = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_depth <= 4'd0;
    end else if (base_depth_en) begin
      base_depth <= cfg_data;
    end
  end

  jsv_classifier u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_req   (byte_req),
    .last       (last),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (!q_full)
  );

  jsv_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid && !q_full),
    .push_item  (f_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  jsv_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .base_depth (base_depth),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted)
  );

endmodule

>>> design/jsv_checker.sv
// Port-level checker for the JSON structure validator, bound to the top level.
// Depends on json_structure_validator_macros.svh.
`include "json_structure_validator_macros.svh"

module jsv_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic accepted,
  input logic cfg_valid,
  input logic cfg_ready
);

  `JSV_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted))
  `JSV_ASSERT_RST(a_rst_out, rst, !out_valid)
  `JSV_ASSERT_IMP(a_in_stall, !in_ready, out_valid)
  `JSV_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind json_structure_validator jsv_checker u_checker (.*);

>>> sim/tb.sv
// Testbench for json_structure_validator: directed, depth-limit and random JSON texts.
// Depends on jsv_pkg and the validator RTL; a local parser predicts each verdict.
module tb;

  localparam int DEPTH_LIMIT  = 16;
  localparam int RANDOM_ITEMS = 540;
  localparam int IDLE_GAP     = 8;

  typedef struct packed {
    logic        accepted;
    logic [31:0] text_no;
  } verdict_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] byte_req;
  logic       last;
  logic       out_valid;
  logic       out_ready;
  logic       accepted;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  // parser state mirrored for prediction
  jsv_pkg::phase_t        prs_phase;
  logic [DEPTH_LIMIT-1:0] open_kind;
  int                     open_count;
  logic [2:0]             hex_owed;
  bit                     text_bad;
  logic [3:0]             depth_base;

  verdict_t   verdict_q[$];
  logic [7:0] text_buf[$];
  int         text_count;
  int         bytes_sent;
  int         mismatches;
  bit         steady_flow;

  json_structure_validator #(.MAX_DEPTH(DEPTH_LIMIT)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_req(byte_req),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------- verdict prediction ----------------

  function automatic bit ws_byte(logic [7:0] b);
    return b == jsv_pkg::CH_SPACE || (b >= jsv_pkg::CH_TAB && b <= jsv_pkg::CH_CR);
  endfunction

  function automatic bit hex_byte(logic [7:0] b);
    return (b >= jsv_pkg::CH_0 && b <= jsv_pkg::CH_9)
        || (b >= jsv_pkg::CH_LA && b <= jsv_pkg::CH_LF)
        || (b >= jsv_pkg::CH_UA && b <= jsv_pkg::CH_UF);
  endfunction

  function automatic bit ends_primitive(logic [7:0] b);
    return ws_byte(b) || b == jsv_pkg::CH_COMMA || b == jsv_pkg::CH_RBRACE
        || b == jsv_pkg::CH_RBRACK;
  endfunction

  function automatic void clear_parser();
    prs_phase  = jsv_pkg::PH_VALUE;
    open_kind  = '0;
    open_count = 0;
    hex_owed   = '0;
    text_bad   = 1'b0;
  endfunction

  function automatic bit inside_object();
    if (open_count == 0 || open_count > DEPTH_LIMIT) return 1'b0;
    return open_kind[open_count-1];
  endfunction

  function automatic void begin_value(logic [7:0] b);
    if (b == jsv_pkg::CH_QUOTE) begin
      prs_phase = jsv_pkg::PH_STR_VAL;
    end else if (b == jsv_pkg::CH_LBRACE || b == jsv_pkg::CH_LBRACK) begin
      if (int'(depth_base) + open_count >= DEPTH_LIMIT) begin
        text_bad = 1'b1;
      end else begin
        open_kind[open_count] = (b == jsv_pkg::CH_LBRACE);
        open_count++;
        prs_phase = (b == jsv_pkg::CH_LBRACE) ? jsv_pkg::PH_KEY_OR_CLOSE
                                              : jsv_pkg::PH_VAL_OR_CLOSE;
      end
    end else if (b == jsv_pkg::CH_COMMA || b == jsv_pkg::CH_RBRACE
                 || b == jsv_pkg::CH_RBRACK) begin
      text_bad = 1'b1;
    end else begin
      prs_phase = jsv_pkg::PH_PRIM;
    end
  endfunction

  function automatic void close_or_next(logic [7:0] b);
    prs_phase = jsv_pkg::PH_AFTER;
    if (ws_byte(b)) return;
    if (open_count == 0) begin
      text_bad = 1'b1;
    end else if (b == jsv_pkg::CH_COMMA) begin
      prs_phase = inside_object() ? jsv_pkg::PH_KEY : jsv_pkg::PH_VALUE;
    end else if (b == (inside_object() ? jsv_pkg::CH_RBRACE : jsv_pkg::CH_RBRACK)) begin
      open_count--;
    end else begin
      text_bad = 1'b1;
    end
  endfunction

  function automatic void string_char(logic [7:0] b, bit is_key);
    if (b == jsv_pkg::CH_QUOTE) begin
      prs_phase = is_key ? jsv_pkg::PH_COLON : jsv_pkg::PH_AFTER;
    end else if (b < jsv_pkg::CTRL_LIMIT) begin
      text_bad = 1'b1;
    end else if (b == jsv_pkg::CH_BSLASH) begin
      prs_phase = is_key ? jsv_pkg::PH_ESC_KEY : jsv_pkg::PH_ESC_VAL;
    end
  endfunction

  function automatic void escape_char(logic [7:0] b, bit is_key);
    if (b == jsv_pkg::CH_QUOTE || b == jsv_pkg::CH_BSLASH || b == jsv_pkg::CH_SLASH
        || b == jsv_pkg::CH_B || b == jsv_pkg::CH_F || b == jsv_pkg::CH_N
        || b == jsv_pkg::CH_R || b == jsv_pkg::CH_T) begin
      prs_phase = is_key ? jsv_pkg::PH_STR_KEY : jsv_pkg::PH_STR_VAL;
    end else if (b == jsv_pkg::CH_U) begin
      hex_owed  = jsv_pkg::HEX_DIGITS;
      prs_phase = is_key ? jsv_pkg::PH_HEX_KEY : jsv_pkg::PH_HEX_VAL;
    end else begin
      text_bad = 1'b1;
    end
  endfunction

  function automatic void unicode_char(logic [7:0] b, bit is_key);
    if (!hex_byte(b)) begin
      text_bad = 1'b1;
      return;
    end
    hex_owed = hex_owed - 3'd1;
    if (hex_owed == 3'd0) prs_phase = is_key ? jsv_pkg::PH_STR_KEY : jsv_pkg::PH_STR_VAL;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (prs_phase)
      jsv_pkg::PH_VALUE: begin
        if (!ws_byte(b)) begin_value(b);
      end
      jsv_pkg::PH_VAL_OR_CLOSE: begin
        if (b == jsv_pkg::CH_RBRACK) begin
          open_count--;
          prs_phase = jsv_pkg::PH_AFTER;
        end else if (!ws_byte(b)) begin
          begin_value(b);
        end
      end
      jsv_pkg::PH_KEY_OR_CLOSE: begin
        if (b == jsv_pkg::CH_RBRACE) begin
          open_count--;
          prs_phase = jsv_pkg::PH_AFTER;
        end else if (b == jsv_pkg::CH_QUOTE) begin
          prs_phase = jsv_pkg::PH_STR_KEY;
        end else if (!ws_byte(b)) begin
          text_bad = 1'b1;
        end
      end
      jsv_pkg::PH_KEY: begin
        if (b == jsv_pkg::CH_QUOTE) prs_phase = jsv_pkg::PH_STR_KEY;
        else if (!ws_byte(b)) text_bad = 1'b1;
      end
      jsv_pkg::PH_COLON: begin
        if (b == jsv_pkg::CH_COLON) prs_phase = jsv_pkg::PH_VALUE;
        else if (!ws_byte(b)) text_bad = 1'b1;
      end
      jsv_pkg::PH_PRIM: begin
        if (ends_primitive(b)) close_or_next(b);
      end
      jsv_pkg::PH_AFTER:   close_or_next(b);
      jsv_pkg::PH_STR_VAL: string_char(b, 1'b0);
      jsv_pkg::PH_ESC_VAL: escape_char(b, 1'b0);
      jsv_pkg::PH_HEX_VAL: unicode_char(b, 1'b0);
      jsv_pkg::PH_STR_KEY: string_char(b, 1'b1);
      jsv_pkg::PH_ESC_KEY: escape_char(b, 1'b1);
      jsv_pkg::PH_HEX_KEY: unicode_char(b, 1'b1);
      default:             text_bad = 1'b1;
    endcase
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic is_last);
    verdict_t v;
    if (!text_bad) parse_byte(b);
    if (is_last) begin
      v.accepted = !text_bad && open_count == 0
                && (prs_phase == jsv_pkg::PH_AFTER || prs_phase == jsv_pkg::PH_PRIM);
      v.text_no  = text_count;
      text_count++;
      verdict_q.push_back(v);
      clear_parser();
    end
  endfunction

  // ---------------- checking ----------------

  function automatic void report_mismatch(string what, logic exp_v, logic got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected accepted=%b, got %b", $time, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with no text pending", 1'bx, accepted);
      end else begin
        v = verdict_q.pop_front();
        if (accepted !== v.accepted)
          report_mismatch($sformatf("text %0d", v.text_no), v.accepted, accepted);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 13);
  end

  // ---------------- driving ----------------

  task automatic send_byte(logic [7:0] b, logic is_last);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_req <= b;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_verdict(b, is_last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_base_depth(logic [3:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    depth_base = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- text generation ----------------

  function automatic logic [7:0] ws_pick();
    int k;
    k = $urandom_range(5);
    return (k == 0) ? jsv_pkg::CH_SPACE : jsv_pkg::CH_TAB + 8'(k - 1);
  endfunction

  function automatic void put_ws();
    int n;
    n = ($urandom_range(99) < 25) ? $urandom_range(1, 2) : 0;
    repeat (n) text_buf.push_back(ws_pick());
  endfunction

  function automatic logic [7:0] escape_pick();
    case ($urandom_range(7))
      0: return jsv_pkg::CH_QUOTE;
      1: return jsv_pkg::CH_BSLASH;
      2: return jsv_pkg::CH_SLASH;
      3: return jsv_pkg::CH_B;
      4: return jsv_pkg::CH_F;
      5: return jsv_pkg::CH_N;
      6: return jsv_pkg::CH_R;
      default: return jsv_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [7:0] hex_pick();
    int v;
    v = $urandom_range(15);
    if (v < 10) return jsv_pkg::CH_0 + 8'(v);
    return ($urandom_range(1) ? jsv_pkg::CH_LA : jsv_pkg::CH_UA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] structural_pick();
    case ($urandom_range(7))
      0: return jsv_pkg::CH_LBRACE;
      1: return jsv_pkg::CH_LBRACK;
      2: return jsv_pkg::CH_RBRACE;
      3: return jsv_pkg::CH_RBRACK;
      4: return jsv_pkg::CH_COMMA;
      5: return jsv_pkg::CH_COLON;
      6: return jsv_pkg::CH_QUOTE;
      default: return jsv_pkg::CH_BSLASH;
    endcase
  endfunction

  function automatic void put_string();
    int n;
    int kind;
    logic [7:0] c;
    text_buf.push_back(jsv_pkg::CH_QUOTE);
    n = $urandom_range(0, 5);
    repeat (n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        do c = 8'($urandom_range(32, 255));
        while (c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_BSLASH);
        text_buf.push_back(c);
      end else if (kind < 85) begin
        text_buf.push_back(jsv_pkg::CH_BSLASH);
        text_buf.push_back(escape_pick());
      end else begin
        text_buf.push_back(jsv_pkg::CH_BSLASH);
        text_buf.push_back(jsv_pkg::CH_U);
        repeat (4) text_buf.push_back(hex_pick());
      end
    end
    text_buf.push_back(jsv_pkg::CH_QUOTE);
  endfunction

  function automatic void put_primitive();
    int n;
    logic [7:0] c;
    do c = 8'($urandom);
    while (ends_primitive(c) || c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_LBRACE
           || c == jsv_pkg::CH_LBRACK);
    text_buf.push_back(c);
    n = $urandom_range(0, 4);
    repeat (n) begin
      do c = 8'($urandom); while (ends_primitive(c));
      text_buf.push_back(c);
    end
  endfunction

  function automatic void put_key();
    put_ws();
    put_string();
    put_ws();
    text_buf.push_back(jsv_pkg::CH_COLON);
    put_ws();
  endfunction

  // well-formed text with nesting up to depth_cap containers
  function automatic void build_text(int depth_cap, int open_pct, int max_members);
    logic [63:0] kind_stk;
    int lvl;
    int members;
    bit want_value;
    bit is_obj;
    text_buf.delete();
    kind_stk   = '0;
    lvl        = 0;
    members    = 0;
    want_value = 1'b1;
    put_ws();
    while (want_value || lvl != 0) begin
      if (want_value) begin
        members++;
        if (lvl < depth_cap && members <= max_members && $urandom_range(99) < open_pct) begin
          is_obj = $urandom_range(1);
          text_buf.push_back(is_obj ? jsv_pkg::CH_LBRACE : jsv_pkg::CH_LBRACK);
          kind_stk[lvl] = is_obj;
          lvl++;
          put_ws();
          if ($urandom_range(99) < (open_pct > 50 ? 5 : 20)) begin
            text_buf.push_back(is_obj ? jsv_pkg::CH_RBRACE : jsv_pkg::CH_RBRACK);
            lvl--;
            want_value = 1'b0;
          end else if (is_obj) begin
            put_key();
          end
        end else begin
          if ($urandom_range(1)) put_string();
          else put_primitive();
          want_value = 1'b0;
        end
      end else begin
        put_ws();
        if (members < max_members && $urandom_range(99) < 50) begin
          text_buf.push_back(jsv_pkg::CH_COMMA);
          put_ws();
          if (kind_stk[lvl-1]) put_key();
          want_value = 1'b1;
        end else begin
          text_buf.push_back(kind_stk[lvl-1] ? jsv_pkg::CH_RBRACE : jsv_pkg::CH_RBRACK);
          lvl--;
        end
      end
    end
    put_ws();
  endfunction

  task automatic send_random_text(int depth_room);
    int pick;
    int pos;
    pick = $urandom_range(99);
    if (pick < 5) begin
      text_buf.delete();
      repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom));
    end else begin
      if ($urandom_range(99) < 10) build_text(depth_room + 1, 85, 40);
      else build_text(depth_room, 35, $urandom_range(1, 6));
      if (pick >= 72) begin
        pos = $urandom_range(text_buf.size() - 1);
        if (pick < 80) begin
          text_buf[pos] = 8'($urandom);
        end else if (pick < 87) begin
          while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
        end else if (pick < 93) begin
          text_buf.push_back(8'($urandom));
        end else begin
          text_buf.insert(pos, structural_pick());
        end
      end
    end
    send_buffer();
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_texts();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text(" ");
    send_text("[");
    send_text("\"\\");
    send_text("{\"\\u0aF9\":[]}");
    send_byte(jsv_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(jsv_pkg::CH_QUOTE, 1'b1);
    send_text("[1}");
  endtask

  task automatic test_depth_limit();
    write_base_depth(4'd0);
    for (int i = 0; i < DEPTH_LIMIT; i++) send_byte(jsv_pkg::CH_LBRACK, 1'b0);
    for (int i = 0; i < DEPTH_LIMIT; i++) send_byte(jsv_pkg::CH_RBRACK, i == DEPTH_LIMIT - 1);
    for (int i = 0; i <= DEPTH_LIMIT; i++) send_byte(jsv_pkg::CH_LBRACK, i == DEPTH_LIMIT);
    write_base_depth(4'd15);
    send_text("[]");
    send_text("[{}]");
    write_base_depth(4'd14);
    send_text("{\"a\":[]}");
    send_text("[[[]]]");
  endtask

  task automatic test_random_texts();
    logic [3:0] plan[6];
    int start_bytes;
    int start_texts;
    plan = '{4'd0, 4'd15, 4'd7, 4'd14, 4'd0, 4'd0};
    plan[4] = 4'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_base_depth(plan[p]);
      steady_flow = (p == 2);
      start_bytes = bytes_sent;
      start_texts = text_count;
      while (bytes_sent - start_bytes < RANDOM_ITEMS / 6 || text_count - start_texts < 2)
        send_random_text(DEPTH_LIMIT - int'(plan[p]));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    byte_req    = '0;
    last        = 1'b0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    steady_flow = 1'b0;
    text_count  = 0;
    bytes_sent  = 0;
    mismatches  = 0;
    depth_base  = '0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_texts();
    test_depth_limit();
    test_random_texts();

    drain_results();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
